[rtl/vn_pkg.sv]
// vector normalize package: widths and the per-cell pipeline record
// used by vn_cell and vector3_normalize; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package vn_pkg;
    localparam int COMP_W = 16;   // signed Q8.8 component
    localparam int ABS_W  = 16;   // magnitude of a component
    localparam int SQ_W   = 31;   // square of a magnitude, at most 2^30
    localparam int SUM_W  = 32;   // sum of three squares
    localparam int ROOT_W = 16;   // length and unit magnitudes
    localparam int PW_W   = 64;   // running q^2 * sum
    localparam int QS_W   = 48;   // running q * sum
    localparam int NCELL  = 16;   // one cell per result bit
    localparam int LIM_SH = 28;   // unit scale 2^14, squared

    // state handed from one cell to the next
    typedef struct packed {
        logic                        valid;
        logic                        zero;
        logic [2:0]                  neg;
        logic [SUM_W-1:0]            sum;
        logic [2:0][SQ_W-1:0]        asq;
        logic [ROOT_W-1:0]           root;
        logic [SUM_W-1:0]            rsq;
        logic [2:0][ROOT_W-1:0]      quo;
        logic [2:0][PW_W-1:0]        pw;
        logic [2:0][QS_W-1:0]        qs;
    } cell_t;
endpackage
`default_nettype wire

[rtl/vector3_normalize.sv]
// vector3_normalize top level: squares, sum, a row of bit cells, output
// register; depends on vn_pkg and vn_cell
//
// channel  dir  fields
// s_       in   tuser: command; tdata: comp_x, comp_y, comp_z
// m_       out  tuser: zero_length; tdata: unit_x, unit_y, unit_z, magnitude
//
// one word per cycle unless m_tready holds the pipeline; stages: squares,
// sum, sixteen bit cells (one per result bit), output register
// aresetn clears all valid flags; payload is not reset
// the whole pipeline holds while the output word waits for m_tready
`timescale 1ns / 1ps
`default_nettype none
module vector3_normalize (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [0:0]  s_tuser,   // [0] command
    input  wire logic [47:0] s_tdata,   // comp_x, comp_y, comp_z
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [0:0]       m_tuser,   // [0] zero_length
    output logic [63:0]      m_tdata    // unit_x, unit_y, unit_z, magnitude
);
    logic ce;
    logic                          sq_valid_reg;
    logic [2:0]                    sq_neg_reg;
    logic [2:0][vn_pkg::SQ_W-1:0]  sq_reg;
    vn_pkg::cell_t                 head_reg;
    vn_pkg::cell_t                 chain [0:vn_pkg::NCELL];
    logic                          out_valid_reg;
    logic [0:0]                    out_user_reg;
    logic [63:0]                   out_data_reg;
    logic [63:0]                   out_data_next;

    assign ce       = !out_valid_reg || m_tready;
    assign s_tready = ce;

    // magnitudes and squares
    always_ff @(posedge aclk) begin
        logic signed [vn_pkg::COMP_W-1:0] c;
        logic [vn_pkg::ABS_W-1:0] a;
        if (!aresetn) begin
            sq_valid_reg <= 1'b0;
        end else if (ce) begin
            sq_valid_reg <= s_tvalid;
            for (int i = 0; i < 3; i++) begin
                c = s_tdata[i*16 +: 16];
                a = c[15] ? vn_pkg::ABS_W'(-c) : vn_pkg::ABS_W'(c);
                sq_reg[i]     <= vn_pkg::SQ_W'(a) * vn_pkg::SQ_W'(a);
                sq_neg_reg[i] <= c[15] ^ s_tuser[0];
            end
        end
    end

    // sum of squares and cell chain seed
    always_ff @(posedge aclk) begin
        logic [vn_pkg::SUM_W-1:0] s;
        if (!aresetn) begin
            head_reg.valid <= 1'b0;
        end else if (ce) begin
            s = vn_pkg::SUM_W'(sq_reg[0]) + vn_pkg::SUM_W'(sq_reg[1])
              + vn_pkg::SUM_W'(sq_reg[2]);
            head_reg.valid <= sq_valid_reg;
            head_reg.zero  <= (s == '0);
            head_reg.neg   <= sq_neg_reg;
            head_reg.sum   <= s;
            head_reg.asq   <= sq_reg;
            head_reg.root  <= '0;
            head_reg.rsq   <= '0;
            head_reg.quo   <= '0;
            head_reg.pw    <= '0;
            head_reg.qs    <= '0;
        end
    end

    assign chain[0] = head_reg;

    // one cell per result bit, most significant first
    for (genvar k = 0; k < vn_pkg::NCELL; k++) begin : g_cell
        vn_cell #(.BIT(vn_pkg::NCELL - 1 - k)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ce      (ce),
            .d_in    (chain[k]),
            .d_out   (chain[k+1])
        );
    end

    // signs and zero vector
    always_comb begin
        vn_pkg::cell_t t;
        t = chain[vn_pkg::NCELL];
        out_data_next = '0;
        if (!t.zero) begin
            for (int i = 0; i < 3; i++) begin
                out_data_next[i*16 +: 16] = t.neg[i] ? 16'(-t.quo[i]) : t.quo[i];
            end
            out_data_next[63:48] = t.root;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            out_valid_reg   <= chain[vn_pkg::NCELL].valid;
            out_user_reg[0] <= chain[vn_pkg::NCELL].zero;
            out_data_reg    <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_user_reg;
    assign m_tdata  = out_data_reg;
endmodule
`default_nettype wire

[rtl/vn_cell.sv]
// vector normalize cell: decides one bit of the length and of each
// unit magnitude; depends on vn_pkg
`timescale 1ns / 1ps
`default_nettype none
module vn_cell #(
    parameter int BIT = 15
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        ce,
    input  wire vn_pkg::cell_t d_in,
    output vn_pkg::cell_t    d_out
);
    vn_pkg::cell_t cell_reg;
    vn_pkg::cell_t cell_next;
    logic [vn_pkg::SUM_W:0] root_cand;

    // trial bit for the root and for each unit quotient
    always_comb begin
        logic [vn_pkg::PW_W-1:0] cand;
        logic [vn_pkg::PW_W-1:0] lim;
        cell_next = d_in;
        root_cand = {1'b0, d_in.rsq}
                  + ((vn_pkg::SUM_W+1)'(d_in.root) << (BIT + 1))
                  + ((vn_pkg::SUM_W+1)'(1) << (2 * BIT));
        if (root_cand <= {1'b0, d_in.sum}) begin
            cell_next.root = d_in.root | (vn_pkg::ROOT_W'(1) << BIT);
            cell_next.rsq  = root_cand[vn_pkg::SUM_W-1:0];
        end
        for (int i = 0; i < 3; i++) begin
            cand = d_in.pw[i]
                 + (vn_pkg::PW_W'(d_in.qs[i]) << (BIT + 1))
                 + (vn_pkg::PW_W'(d_in.sum) << (2 * BIT));
            lim  = vn_pkg::PW_W'(d_in.asq[i]) << vn_pkg::LIM_SH;
            if (cand <= lim) begin
                cell_next.quo[i] = d_in.quo[i] | (vn_pkg::ROOT_W'(1) << BIT);
                cell_next.pw[i]  = cand;
                cell_next.qs[i]  = d_in.qs[i] + (vn_pkg::QS_W'(d_in.sum) << BIT);
            end
        end
    end

    // stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (ce) begin
            cell_reg <= cell_next;
        end
    end

    assign d_out = cell_reg;
endmodule
`default_nettype wire

[tb/sv/vector3_normalize_test.sv]
// testbench for vector3_normalize: drives vectors and commands, predicts the
// normalized result of each, checks every output word in order; needs the rtl only
`timescale 1ns / 1ps
`default_nettype none

// scoreboard: predicts a unit vector and length for each accepted word
class norm_scoreboard;
    logic [80:0] pending_q[$];   // {zero_length, magnitude, zero pad, unit_z, unit_y, unit_x}
    int mismatches;
    int words_checked;

    function new();
        mismatches = 0;
        words_checked = 0;
    endfunction

    // floor of the square root of the sum of squares
    static function logic [15:0] length_floor(logic [63:0] sq_sum);
        logic [15:0] r;
        logic [63:0] t;
        r = 0;
        for (int b = 15; b >= 0; b--) begin
            t = {48'd0, r | (16'd1 << b)};
            if (t * t <= sq_sum) r = t[15:0];
        end
        return r;
    endfunction

    // truncated |c| * 2^14 / exact length
    static function logic [15:0] unit_part(logic [31:0] a, logic [63:0] sq_sum);
        logic [15:0] q;
        logic [127:0] t, lim;
        lim = ({96'd0, a} * {96'd0, a}) << 28;
        q = 0;
        for (int b = 14; b >= 0; b--) begin
            t = {112'd0, q | (16'd1 << b)};
            if (t * t * {64'd0, sq_sum} <= lim) q = t[15:0];
        end
        return q;
    endfunction

    function void note_vector(logic cmd, logic [47:0] comps);
        logic signed [15:0] c [3];
        logic [31:0] a [3];
        logic [63:0] sq_sum;
        logic [15:0] u [3];
        logic [15:0] q;
        sq_sum = 0;
        for (int i = 0; i < 3; i++) begin
            c[i] = comps[16*i +: 16];
            a[i] = c[i] < 0 ? 32'(-int'(c[i])) : 32'(int'(c[i]));
            sq_sum += {32'd0, a[i]} * {32'd0, a[i]};
        end
        if (sq_sum == 0) begin
            pending_q.push_back({1'b1, 80'd0});
            return;
        end
        for (int i = 0; i < 3; i++) begin
            q = unit_part(a[i], sq_sum);
            u[i] = ((c[i] < 0) != cmd) ? 16'(-q) : q;
        end
        pending_q.push_back({1'b0, length_floor(sq_sum), 16'd0, u[2], u[1], u[0]});
    endfunction

    function void check_word(logic zl, logic [63:0] data);
        logic [80:0] want, got;
        got = {zl, data[63:48], 16'd0, data[47:0]};
        if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected output word %h", data);
            return;
        end
        want = pending_q.pop_front();
        words_checked++;
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp zl=%b mag=%h z=%h y=%h x=%h, got zl=%b mag=%h z=%h y=%h x=%h",
                    want[80], want[79:64], want[47:32], want[31:16], want[15:0],
                    got[80], got[79:64], got[47:32], got[31:16], got[15:0]);
        end
    endfunction
endclass

module vector3_normalize_test;
    localparam int LATENCY = 19;
    localparam int RANDOM_WORDS = 630;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [0:0]  s_tuser = 0;   // [0] command
    logic [47:0] s_tdata = 0;   // comp_x, comp_y, comp_z
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [0:0]  m_tuser;       // [0] zero_length
    logic [63:0] m_tdata;       // unit_x, unit_y, unit_z, magnitude

    norm_scoreboard sb = new();
    bit quiet_tail = 0;
    bit long_hold = 0;
    int sent = 0;

    vector3_normalize u_top (.*);

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    // offer one word at a falling edge and hold it until taken
    task automatic send_word(logic cmd, logic [47:0] comps);
        s_tuser <= cmd;
        s_tdata <= comps;
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        sb.note_vector(cmd, comps);
        sent++;
        @(negedge aclk);
    endtask

    // withdraw the offer and idle for a number of cycles
    task automatic idle_sender(int cycles);
        s_tvalid <= 0;
        repeat (cycles) @(negedge aclk);
    endtask

    task automatic send_random(int count);
        logic [15:0] v [3];
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < 3; i++)
                case ($urandom_range(0, 5))
                    0: v[i] = 16'($urandom_range(0, 15) - 8);
                    1: v[i] = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                    2: v[i] = 0;
                    default: v[i] = 16'($urandom);
                endcase
            if ($urandom_range(0, 40) == 0) v = '{0, 0, 0};
            send_word(1'($urandom_range(0, 1)), {v[2], v[1], v[0]});
            if (!quiet_tail && !long_hold && $urandom_range(0, 3) == 0)
                idle_sender($urandom_range(1, 5));
        end
    endtask

    // receiver: random stall bursts, one long hold-off
    initial begin
        @(negedge aclk);
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_tready <= 0;
                repeat (60) @(negedge aclk);
                long_hold = 0;
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 5) - 1) @(negedge aclk);
            end else
                m_tready <= 1;
        end
    end

    // check output words at the rising edge
    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tuser[0], m_tdata);

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        // directed: zero vector both commands, extremes, axes, tiny values
        send_word(1'b0, 48'd0);
        send_word(1'b1, 48'd0);
        send_word(1'b0, {16'h8000, 16'h8000, 16'h8000});
        send_word(1'b1, {16'h8000, 16'h8000, 16'h8000});
        send_word(1'b0, {16'h7fff, 16'h7fff, 16'h7fff});
        send_word(1'b1, {16'h7fff, 16'h8000, 16'h7fff});
        send_word(1'b0, {16'd0, 16'd0, 16'd1});
        send_word(1'b1, {16'd0, 16'd1, 16'd0});
        send_word(1'b0, {16'hffff, 16'd0, 16'd0});
        send_word(1'b1, {16'hffff, 16'hffff, 16'hffff});
        send_word(1'b0, {16'd0, 16'h8000, 16'd0});
        send_word(1'b1, {16'd0, 16'd0, 16'h7fff});
        send_word(1'b0, {16'd1, 16'd1, 16'd1});
        send_word(1'b0, {16'h5555, 16'haaaa, 16'h0f0f});
        send_word(1'b1, {16'haaaa, 16'h5555, 16'hf0f0});
        send_word(1'b0, {16'd0, 16'd4, 16'd3});
        // pause until the pipeline drains
        s_tvalid <= 0;
        wait (sb.pending_q.size() == 0);
        @(negedge aclk);
        send_random(RANDOM_WORDS / 3);
        // long receiver hold-off while words keep coming
        long_hold = 1;
        send_random(40);
        s_tvalid <= 0;
        wait (!long_hold);
        @(negedge aclk);
        send_random(RANDOM_WORDS / 3);
        quiet_tail = 1;
        send_random(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3) - 40);
        s_tvalid <= 0;
        wait (sb.pending_q.size() == 0);
        repeat (LATENCY + 5) @(posedge aclk);
        $display("sent %0d vectors, checked %0d normalized words", sent, sb.words_checked);
        $display("covered zero vectors, component extremes, both commands and stalls");
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire

[vector3_normalize.f]
rtl/vn_pkg.sv
rtl/vn_cell.sv
rtl/vector3_normalize.sv
tb/sv/vector3_normalize_test.sv
